FILE: rtl/rrps_pkg.sv
// Shared types and constants of the round-robin process scheduler.
package rrps_pkg;

  localparam int unsigned SlotInW = 4;
  localparam int unsigned PidW    = 16;
  localparam int unsigned QlenW   = 5;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 40;

  typedef enum logic [2:0] {
    MODE_CREATE  = 3'd0,
    MODE_START   = 3'd1,
    MODE_DESTROY = 3'd2,
    MODE_BLOCK   = 3'd3,
    MODE_UNBLOCK = 3'd4,
    MODE_TICK    = 3'd5,
    MODE_INIT    = 3'd6
  } mode_e;

  typedef enum logic [2:0] {
    RES_OK        = 3'd0,
    RES_NOT_INIT  = 3'd1,
    RES_NO_FREE   = 3'd2,
    RES_WRONG     = 3'd3,
    RES_FREE_SLOT = 3'd4,
    RES_NOTHING   = 3'd5
  } res_e;

  typedef enum logic [1:0] {
    SST_READY   = 2'd0,
    SST_RUNNING = 2'd1,
    SST_BLOCKED = 2'd2,
    SST_TERM    = 2'd3
  } sst_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_TICK,
    S_HEAD,
    S_REMOVE,
    S_DISPATCH,
    S_READ,
    S_OUT
  } fsm_e;

endpackage

FILE: rtl/round_robin_process_scheduler.sv
// Top level of the round-robin process scheduler: task table, ready queue and sequencer.
//
//  channel  | direction | tdata fields (lowest bit first)
//  s_axis   | in        | mode[2:0], slot[6:3], zero pad[7]
//  m_axis   | out       | status[2:0], slot_out[6:3], pid_out[22:7], current_valid[23],
//           |           | current_slot[27:24], queue_length[32:28], zero pad[39:33]
//
// A command word is taken only in the idle state. Each command runs the idle, execute,
// memory read and output states. Create also scans the table slot by slot; destroy or block
// of a queued process walks the queue entry by entry; a tick or a block of the running
// process reads the queue head, walks the queue and dispatches, unless the queue is empty.
// A result waits in the output register while the next word runs; a second result holds
// the sequencer in its output state until the first is taken. Reset leaves the table empty.
module round_robin_process_scheduler #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [rrps_pkg::InDataW-1:0]  s_axis_tdata,   // mode[2:0], slot[6:3]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [rrps_pkg::OutDataW-1:0] m_axis_tdata    // status, slot_out, pid_out,
                                                        // current_valid, current_slot,
                                                        // queue_length
);
  import rrps_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned RW = (SW > SlotInW) ? SW : SlotInW;

  fsm_e               state_q, state_d, post_q, post_d;
  mode_e              mode_q, mode_d;
  logic [RW-1:0]      slot_q, slot_d;
  logic [SW-1:0]      target_q, target_d;
  logic [SW-1:0]      idx_q, idx_d;
  logic               found_q, found_d;
  logic               report_q, report_d;
  res_e               res_status_q, res_status_d;
  logic [RW-1:0]      res_slot_q, res_slot_d;
  sst_e               st_q [SLOTS];
  sst_e               st_d [SLOTS];
  logic [SLOTS-1:0]   queued_q, queued_d;
  logic [CW-1:0]      count_q, count_d;
  logic [SW-1:0]      run_slot_q, run_slot_d;
  logic               run_valid_q, run_valid_d;
  logic [PidW-1:0]    pid_ctr_q, pid_ctr_d;
  logic               sys_ready_q, sys_ready_d;
  logic               m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q, m_data_d;

  logic [SW-1:0]      ord_mem [SLOTS];
  logic               ord_we;
  logic [SW-1:0]      ord_waddr, ord_wdata, ord_raddr, ord_rd_q;
  logic [PidW-1:0]    pid_mem [SLOTS];
  logic               pid_we;
  logic [SW-1:0]      pid_waddr, pid_raddr;
  logic [PidW-1:0]    pid_wdata, pid_rd_q;

  logic [SW-1:0]      s_idx, res_idx;
  logic               s_in_rng, res_in_rng, live, match;
  logic [PidW-1:0]    pid_out;
  logic [SW-1:0]      cur_slot;

  assign s_idx      = slot_q[SW-1:0];
  assign res_idx    = res_slot_q[SW-1:0];
  assign s_in_rng   = {1'b0, slot_q} < (RW+1)'(SLOTS);
  assign res_in_rng = {1'b0, res_slot_q} < (RW+1)'(SLOTS);
  assign live       = s_in_rng && (st_q[s_idx] != SST_TERM);
  assign match      = (ord_rd_q == target_q);
  assign pid_raddr  = res_idx;
  assign pid_out    = (res_in_rng && (st_q[res_idx] != SST_TERM)) ? pid_rd_q : '0;
  assign cur_slot   = run_valid_q ? run_slot_q : '0;

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    state_d      = state_q;
    post_d       = post_q;
    mode_d       = mode_q;
    slot_d       = slot_q;
    target_d     = target_q;
    idx_d        = idx_q;
    found_d      = found_q;
    report_d     = report_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    st_d         = st_q;
    queued_d     = queued_q;
    count_d      = count_q;
    run_slot_d   = run_slot_q;
    run_valid_d  = run_valid_q;
    pid_ctr_d    = pid_ctr_q;
    sys_ready_d  = sys_ready_q;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    ord_we       = 1'b0;
    ord_waddr    = '0;
    ord_wdata    = '0;
    ord_raddr    = '0;
    pid_we       = 1'b0;
    pid_waddr    = '0;
    pid_wdata    = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          mode_d  = mode_e'(s_axis_tdata[2:0]);
          slot_d  = RW'(s_axis_tdata[6:3]);
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_status_d = RES_OK;
        res_slot_d   = '0;
        report_d     = 1'b0;
        found_d      = 1'b0;
        idx_d        = '0;
        state_d      = S_READ;
        if (mode_q == MODE_INIT) begin
          for (int i = 0; i < SLOTS; i++) begin
            st_d[i] = SST_TERM;
          end
          queued_d    = '0;
          count_d     = '0;
          run_slot_d  = '0;
          run_valid_d = 1'b0;
          pid_ctr_d   = PidW'(1);
          sys_ready_d = 1'b1;
        end else if (!sys_ready_q) begin
          case (mode_q)
            MODE_CREATE, MODE_START, MODE_DESTROY, MODE_BLOCK,
            MODE_UNBLOCK, MODE_TICK: res_status_d = RES_NOT_INIT;
            default: res_status_d = RES_OK;
          endcase
        end else begin
          case (mode_q)
            MODE_CREATE: begin
              state_d = S_SCAN;
            end
            MODE_TICK: begin
              report_d = 1'b1;
              state_d  = S_TICK;
            end
            MODE_START, MODE_DESTROY, MODE_BLOCK, MODE_UNBLOCK: begin
              res_slot_d = slot_q;
              target_d   = s_idx;
              if (!live) begin
                res_status_d = RES_FREE_SLOT;
              end else begin
                case (mode_q)
                  MODE_START: begin
                    if (st_q[s_idx] != SST_READY || queued_q[s_idx]) begin
                      res_status_d = RES_WRONG;
                    end else begin
                      ord_we           = 1'b1;
                      ord_waddr        = count_q[SW-1:0];
                      ord_wdata        = s_idx;
                      count_d          = count_q + CW'(1);
                      queued_d[s_idx]  = 1'b1;
                    end
                  end
                  MODE_DESTROY: begin
                    st_d[s_idx] = SST_TERM;
                    if (run_valid_q && run_slot_q == s_idx) begin
                      run_valid_d = 1'b0;
                      run_slot_d  = '0;
                    end
                    post_d = S_READ;
                    if (queued_q[s_idx]) begin
                      state_d = S_REMOVE;
                    end
                  end
                  MODE_BLOCK: begin
                    st_d[s_idx] = SST_BLOCKED;
                    post_d      = S_READ;
                    if (run_valid_q && run_slot_q == s_idx) begin
                      run_valid_d = 1'b0;
                      run_slot_d  = '0;
                      post_d      = S_TICK;
                    end
                    if (queued_q[s_idx]) begin
                      state_d = S_REMOVE;
                    end else begin
                      state_d = post_d;
                    end
                  end
                  default: begin
                    if (st_q[s_idx] != SST_BLOCKED) begin
                      res_status_d = RES_WRONG;
                    end else begin
                      st_d[s_idx]     = SST_READY;
                      ord_we          = 1'b1;
                      ord_waddr       = count_q[SW-1:0];
                      ord_wdata       = s_idx;
                      count_d         = count_q + CW'(1);
                      queued_d[s_idx] = 1'b1;
                    end
                  end
                endcase
              end
            end
            default: res_status_d = RES_OK;
          endcase
        end
      end

      S_SCAN: begin
        if (st_q[idx_q] == SST_TERM) begin
          pid_we        = 1'b1;
          pid_waddr     = idx_q;
          pid_wdata     = pid_ctr_q;
          st_d[idx_q]   = SST_READY;
          queued_d[idx_q] = 1'b0;
          pid_ctr_d     = (pid_ctr_q == '1) ? PidW'(1) : pid_ctr_q + PidW'(1);
          res_slot_d    = RW'(idx_q);
          res_status_d  = RES_OK;
          state_d       = S_READ;
        end else if (idx_q == SW'(SLOTS - 1)) begin
          res_status_d = RES_NO_FREE;
          state_d      = S_READ;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end

      S_TICK: begin
        if (count_q == '0) begin
          if (report_q) begin
            res_status_d = RES_NOTHING;
            res_slot_d   = '0;
          end
          state_d = S_READ;
        end else begin
          if (run_valid_q && st_q[run_slot_q] == SST_RUNNING &&
              !queued_q[run_slot_q]) begin
            st_d[run_slot_q]     = SST_READY;
            ord_we               = 1'b1;
            ord_waddr            = count_q[SW-1:0];
            ord_wdata            = run_slot_q;
            count_d              = count_q + CW'(1);
            queued_d[run_slot_q] = 1'b1;
          end
          state_d = S_HEAD;
        end
      end

      S_HEAD: begin
        target_d = ord_rd_q;
        idx_d    = '0;
        found_d  = 1'b0;
        post_d   = S_DISPATCH;
        state_d  = S_REMOVE;
      end

      S_REMOVE: begin
        ord_raddr = idx_q + SW'(1);
        if (found_q) begin
          ord_we    = 1'b1;
          ord_waddr = idx_q - SW'(1);
          ord_wdata = ord_rd_q;
        end
        found_d = found_q || match;
        if (CW'(idx_q) + CW'(1) == count_q) begin
          if (found_q || match) begin
            count_d = count_q - CW'(1);
          end
          queued_d[target_q] = 1'b0;
          state_d            = post_q;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end

      S_DISPATCH: begin
        st_d[target_q] = SST_RUNNING;
        run_slot_d     = target_q;
        run_valid_d    = 1'b1;
        if (report_q) begin
          res_slot_d = RW'(target_q);
        end
        state_d = S_READ;
      end

      S_READ: begin
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {7'b0, QlenW'(count_q), SlotInW'(cur_slot), run_valid_q, pid_out,
                       SlotInW'(res_slot_q), res_status_q};
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      post_q       <= S_READ;
      mode_q       <= MODE_INIT;
      slot_q       <= '0;
      target_q     <= '0;
      idx_q        <= '0;
      found_q      <= 1'b0;
      report_q     <= 1'b0;
      res_status_q <= RES_OK;
      res_slot_q   <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        st_q[i] <= SST_TERM;
      end
      queued_q     <= '0;
      count_q      <= '0;
      run_slot_q   <= '0;
      run_valid_q  <= 1'b0;
      pid_ctr_q    <= PidW'(1);
      sys_ready_q  <= 1'b0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
    end else begin
      state_q      <= state_d;
      post_q       <= post_d;
      mode_q       <= mode_d;
      slot_q       <= slot_d;
      target_q     <= target_d;
      idx_q        <= idx_d;
      found_q      <= found_d;
      report_q     <= report_d;
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      st_q         <= st_d;
      queued_q     <= queued_d;
      count_q      <= count_d;
      run_slot_q   <= run_slot_d;
      run_valid_q  <= run_valid_d;
      pid_ctr_q    <= pid_ctr_d;
      sys_ready_q  <= sys_ready_d;
      m_valid_q    <= m_valid_d;
      m_data_q     <= m_data_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rd_q <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pid_we) begin
      pid_mem[pid_waddr] <= pid_wdata;
    end
    pid_rd_q <= pid_mem[pid_raddr];
  end

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the round-robin process scheduler.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrps_pkg::*;

  localparam int unsigned NumSlots = 16;
  localparam logic [2:0] ModeSpare = 3'd7;

  typedef struct packed {
    logic [6:0]  pad;
    logic [4:0]  qlen;
    logic [3:0]  cur_slot;
    logic        cur_valid;
    logic [15:0] pid;
    logic [3:0]  slot;
    logic [2:0]  status;
  } sched_word_t;

  class sched_scoreboard;
    logic [15:0] pid_tab[NumSlots];
    sst_e        state_tab[NumSlots];
    bit          queued[NumSlots];
    logic [3:0]  ready_q[$];
    bit          run_valid;
    logic [3:0]  run_slot;
    logic [15:0] issue_pid;
    bit          armed;
    sched_word_t expected_q[$];
    int          errors;
    int          checked;
    int          n_cmd[8];
    int          n_status[8];

    function new();
      clear_table();
      armed = 0;
    endfunction

    function void clear_table();
      for (int i = 0; i < NumSlots; i++) begin
        pid_tab[i] = '0;
        state_tab[i] = SST_TERM;
        queued[i] = 0;
      end
      ready_q.delete();
      run_valid = 0;
      run_slot = '0;
      issue_pid = 16'd1;
    endfunction

    function void enqueue(logic [3:0] s);
      if (queued[s] || ready_q.size() >= NumSlots) return;
      ready_q.push_back(s);
      queued[s] = 1;
    endfunction

    function void unqueue(logic [3:0] s);
      if (!queued[s]) return;
      for (int k = 0; k < ready_q.size(); k++) begin
        if (ready_q[k] == s) begin
          ready_q.delete(k);
          break;
        end
      end
      queued[s] = 0;
    endfunction

    function bit dispatch(output logic [3:0] picked);
      picked = '0;
      if (ready_q.size() == 0) return 0;
      if (run_valid && state_tab[run_slot] == SST_RUNNING) begin
        state_tab[run_slot] = SST_READY;
        enqueue(run_slot);
      end
      picked = ready_q[0];
      unqueue(picked);
      state_tab[picked] = SST_RUNNING;
      run_slot = picked;
      run_valid = 1;
      return 1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // prefer slots where the command does real work
    function logic [3:0] pick_slot(logic [2:0] mode);
      logic [3:0] pool[$];
      if ($urandom_range(99) < 25) return 4'($urandom_range(15));
      for (int i = 0; i < NumSlots; i++) begin
        if (pid_tab[i] != 0) begin
          if (mode == MODE_START) begin
            if (state_tab[i] == SST_READY && !queued[i]) pool.push_back(4'(i));
          end else if (mode == MODE_UNBLOCK) begin
            if (state_tab[i] == SST_BLOCKED) pool.push_back(4'(i));
          end else begin
            pool.push_back(4'(i));
          end
        end
      end
      if (pool.size() == 0) return 4'($urandom_range(15));
      return pool[$urandom_range(pool.size() - 1)];
    endfunction

    function void note(logic [2:0] mode, logic [3:0] slot);
      sched_word_t w;
      logic [3:0]  picked;
      bit          live;
      w = '0;
      live = pid_tab[slot] != 0;
      n_cmd[mode]++;
      if (mode == MODE_INIT) begin
        clear_table();
        armed = 1;
      end else if (!armed) begin
        if (mode != ModeSpare) w.status = RES_NOT_INIT;
      end else begin
        case (mode)
          MODE_CREATE: begin
            w.status = RES_NO_FREE;
            for (int i = 0; i < NumSlots; i++) begin
              if (pid_tab[i] == 0) begin
                pid_tab[i] = issue_pid;
                state_tab[i] = SST_READY;
                queued[i] = 0;
                issue_pid = (issue_pid == 16'hFFFF) ? 16'd1 : issue_pid + 16'd1;
                w.status = RES_OK;
                w.slot = 4'(i);
                break;
              end
            end
          end
          MODE_START, MODE_DESTROY, MODE_BLOCK, MODE_UNBLOCK: begin
            w.slot = slot;
            if (!live) begin
              w.status = RES_FREE_SLOT;
            end else if (mode == MODE_START) begin
              if (state_tab[slot] != SST_READY || queued[slot]) w.status = RES_WRONG;
              else enqueue(slot);
            end else if (mode == MODE_DESTROY) begin
              unqueue(slot);
              if (run_valid && run_slot == slot) begin
                run_valid = 0;
                run_slot = '0;
              end
              state_tab[slot] = SST_TERM;
              pid_tab[slot] = '0;
            end else if (mode == MODE_BLOCK) begin
              state_tab[slot] = SST_BLOCKED;
              unqueue(slot);
              if (run_valid && run_slot == slot) begin
                run_valid = 0;
                run_slot = '0;
                void'(dispatch(picked));
              end
            end else begin
              if (state_tab[slot] != SST_BLOCKED) begin
                w.status = RES_WRONG;
              end else begin
                state_tab[slot] = SST_READY;
                enqueue(slot);
              end
            end
          end
          MODE_TICK: begin
            if (dispatch(picked)) w.slot = picked;
            else w.status = RES_NOTHING;
          end
          default: ;
        endcase
      end
      w.pid = pid_tab[w.slot];
      w.cur_valid = run_valid;
      w.cur_slot = run_valid ? run_slot : 4'd0;
      w.qlen = 5'(ready_q.size());
      n_status[w.status]++;
      expected_q.push_back(w);
    endfunction

    function void cmp(string name, int exp_v, int got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check(logic [39:0] data);
      sched_word_t got;
      sched_word_t exp_w;
      got = data;
      if (expected_q.size() == 0) begin
        $error("result word 0x%010h with no command pending", data);
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      checked++;
      cmp("status", exp_w.status, got.status);
      cmp("slot_out", exp_w.slot, got.slot);
      cmp("pid_out", exp_w.pid, got.pid);
      cmp("current_valid", exp_w.cur_valid, got.cur_valid);
      cmp("current_slot", exp_w.cur_slot, got.cur_slot);
      cmp("queue_length", exp_w.qlen, got.qlen);
      cmp("pad", 0, got.pad);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  sched_scoreboard sb = new();
  bit calm_tx = 0;

  round_robin_process_scheduler #(.SLOTS(NumSlots)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("round_robin_process_scheduler: mismatch");
    $finish;
  end

  task automatic send_cmd(logic [2:0] mode, logic [3:0] slot);
    while (!calm_tx && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, slot, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note(mode, slot);
  endtask

  // receiver: random stalls, one long hold-off, one calm stretch
  initial begin
    int got;
    int hold_left;
    bit held;
    got = 0;
    hold_left = 0;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        sb.check(m_axis_tdata);
        got++;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (got == 60 && !held) begin
        held = 1;
        hold_left = 300;
        m_axis_tready <= 1'b0;
      end else if (got >= 250 && got < 330) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 16);
      end
    end
  end

  initial begin
    int r;
    logic [2:0] mode;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(MODE_CREATE, 4'd0);
    send_cmd(MODE_START, 4'd15);
    send_cmd(ModeSpare, 4'd9);
    send_cmd(MODE_TICK, 4'd0);
    send_cmd(MODE_INIT, 4'd0);
    send_cmd(MODE_START, 4'd3);
    send_cmd(ModeSpare, 4'd5);
    send_cmd(MODE_TICK, 4'd0);
    send_cmd(MODE_CREATE, 4'd0);
    send_cmd(MODE_CREATE, 4'd0);
    send_cmd(MODE_START, 4'd0);
    send_cmd(MODE_START, 4'd0);
    send_cmd(MODE_UNBLOCK, 4'd0);
    send_cmd(MODE_TICK, 4'd0);
    send_cmd(MODE_START, 4'd1);
    send_cmd(MODE_TICK, 4'd0);
    send_cmd(MODE_BLOCK, 4'd1);
    send_cmd(MODE_UNBLOCK, 4'd1);
    send_cmd(MODE_START, 4'd1);
    send_cmd(MODE_DESTROY, 4'd0);
    send_cmd(MODE_TICK, 4'd0);
    send_cmd(MODE_BLOCK, 4'd15);
    send_cmd(MODE_DESTROY, 4'd1);
    send_cmd(MODE_TICK, 4'd0);
    send_cmd(MODE_CREATE, 4'd0);

    for (int n = 0; n < 530; n++) begin
      calm_tx = (n >= 200 && n < 280);
      if (n == 350) begin
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
      r = $urandom_range(99);
      if (r < 24) mode = MODE_CREATE;
      else if (r < 42) mode = MODE_START;
      else if (r < 49) mode = MODE_DESTROY;
      else if (r < 60) mode = MODE_BLOCK;
      else if (r < 72) mode = MODE_UNBLOCK;
      else if (r < 97) mode = MODE_TICK;
      else if (r < 98) mode = MODE_INIT;
      else mode = ModeSpare;
      send_cmd(mode, sb.pick_slot(mode));
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2 * NumSlots + 10) @(posedge clk_i);

    $display("checked %0d result words; create %0d start %0d destroy %0d block %0d",
             sb.checked, sb.n_cmd[MODE_CREATE], sb.n_cmd[MODE_START],
             sb.n_cmd[MODE_DESTROY], sb.n_cmd[MODE_BLOCK]);
    $display("unblock %0d tick %0d init %0d spare %0d; no-free %0d wrong %0d idle-tick %0d",
             sb.n_cmd[MODE_UNBLOCK], sb.n_cmd[MODE_TICK], sb.n_cmd[MODE_INIT],
             sb.n_cmd[ModeSpare], sb.n_status[RES_NO_FREE], sb.n_status[RES_WRONG],
             sb.n_status[RES_NOTHING]);
    if (sb.errors == 0) begin
      $display("round_robin_process_scheduler: match");
    end else begin
      $display("round_robin_process_scheduler: mismatch");
    end
    $finish;
  end
endmodule
